FILE: design/vids_pkg.sv
// Shared types, codes and sizes for the visible id distinct set collector.
package vids_pkg;

	// Table size and derived widths
	localparam int SET_DEPTH = 4096;
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);
	localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

	// Input command codes
	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_FRAME = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Background object and the last-id value after reset or frame start
	localparam logic [15:0] BACKGROUND_OBJ = 16'hFFFF;
	localparam logic [31:0] LAST_ID_RESET  = 32'h0000_FFFF;

	// Work handed from the front to the back
	typedef enum logic [1:0] {
		JOB_REPORT,
		JOB_SEARCH,
		JOB_CLEAR
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] id;
	} job_t;

	// One result beat
	typedef struct packed {
		logic        inserted;
		logic [11:0] entry_index;
		logic [31:0] entry_value;
		logic [12:0] set_count;
		logic        overflow;
	} result_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

endpackage

FILE: design/visible_id_distinct_set.sv
// Top level of the visible id distinct set collector.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  input    | push / full      | command, object_id, poly_id
//  result   | empty / pop      | inserted, entry_index, entry_value, set_count,
//           |                  | overflow
//
// Frame start, clear, unused commands and filtered pixels are answered straight from
// the idle state of the back end. With n ids held, a pixel that needs a search reads
// the table from the first entry on, one table read per cycle on the single read port,
// and scans all n when the id is new or dropped, stopping early when it is found. The
// front keeps accepting into a two-entry job queue meanwhile.
// Reset clears counters, flags and queues; the table needs no clearing pass.
// A stalled result side stops the back end once two results wait.
module visible_id_distinct_set
	import vids_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [15:0] object_id,
	input  logic [15:0] poly_id,
	output logic        empty,
	input  logic        pop,
	output logic        inserted,
	output logic [11:0] entry_index,
	output logic [31:0] entry_value,
	output logic [12:0] set_count,
	output logic        overflow
);

	job_t    job;
	logic    job_empty;
	logic    job_pop;
	result_t res;

	vids_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.object_id(object_id),
		.poly_id  (poly_id),
		.job_pop  (job_pop),
		.job      (job),
		.job_empty(job_empty)
	);

	vids_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	// Unpack the result beat
	assign inserted    = res.inserted;
	assign entry_index = res.entry_index;
	assign entry_value = res.entry_value;
	assign set_count   = res.set_count;
	assign overflow    = res.overflow;

endmodule

FILE: design/vids_jobq.sv
// Two-entry job queue between the classifying front and the searching back.
module vids_jobq
	import vids_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	input  logic pop,
	output job_t job_out,
	output logic empty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign job_out = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store an incoming job
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/vids_front.sv
// Front end: accepts input beats, applies the background and repeat filter, queues jobs.
module vids_front
	import vids_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [15:0] object_id,
	input  logic [15:0] poly_id,
	input  logic        job_pop,
	output job_t        job,
	output logic        job_empty
);

	logic [31:0] last_id_q;
	logic [31:0] pix_id;
	logic        accept;
	logic        set_last;
	logic [31:0] last_d;
	job_t        job_d;

	assign pix_id = {object_id, poly_id};
	assign accept = push && !full;

	// Classify the beat
	always_comb begin
		job_d.kind = JOB_REPORT;
		job_d.id   = 32'd0;
		set_last   = 1'b0;
		last_d     = last_id_q;
		case (command)
			CMD_PIXEL: begin
				job_d.id = pix_id;
				if (object_id != BACKGROUND_OBJ && pix_id != last_id_q) begin
					job_d.kind = JOB_SEARCH;
					set_last   = 1'b1;
					last_d     = pix_id;
				end
			end
			CMD_FRAME: begin
				set_last = 1'b1;
				last_d   = LAST_ID_RESET;
			end
			CMD_CLEAR: begin
				job_d.kind = JOB_CLEAR;
			end
			default: begin
				job_d.kind = JOB_REPORT;
			end
		endcase
	end

	// Hold the last id seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q <= LAST_ID_RESET;
		end else if (accept && set_last) begin
			last_id_q <= last_d;
		end
	end

	vids_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job_in (job_d),
		.full   (full),
		.pop    (job_pop),
		.job_out(job),
		.empty  (job_empty)
	);

endmodule

FILE: design/vids_back.sv
// Back end: id table, linear search, append, counters and the result queue.
module vids_back
	import vids_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_empty,
	output logic        job_pop,
	input  logic        pop,
	output logic        empty,
	output result_t     res
);

	logic [31:0]      id_table [SET_DEPTH];
	back_state_t      state_q;
	back_state_t      state_d;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] k_q;
	logic             pend_q;
	logic [31:0]      rdata_q;
	logic [31:0]      key_q;

	result_t          res_q [2];
	logic             res_wr_ptr_q;
	logic             res_rd_ptr_q;
	logic [1:0]       res_cnt_q;

	logic             res_full;
	logic             hit;
	logic             exhausted;
	logic             scan_done;
	logic             rd_en;
	logic             take_job;
	logic             table_room;
	logic             do_insert;
	logic             res_wr;
	logic             res_rd;
	result_t          res_d;
	logic [CNT_W-1:0] count_d;
	logic             ovf_d;
	logic [31:0]      count_now32;
	logic [31:0]      count_new32;

	assign res_full   = (res_cnt_q == 2'd2);
	assign empty      = (res_cnt_q == 2'd0);
	assign res        = res_q[res_rd_ptr_q];
	assign res_rd     = pop && !empty;

	assign hit        = pend_q && (rdata_q == key_q);
	assign exhausted  = (k_q == count_q) && !hit;
	assign scan_done  = hit || exhausted;
	assign table_room = (count_q < CNT_W'(SET_DEPTH));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty && !res_full && job.kind == JOB_SEARCH) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		take_job  = 1'b0;
		rd_en     = 1'b0;
		do_insert = 1'b0;
		res_wr    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				take_job = !job_empty && !res_full;
				res_wr   = take_job && (job.kind != JOB_SEARCH);
			end
			BK_SCAN: begin
				rd_en     = !scan_done && (k_q != count_q);
				res_wr    = scan_done;
				do_insert = exhausted && table_room;
			end
			default: begin
				take_job = 1'b0;
			end
		endcase
	end

	assign job_pop = take_job;

	// Work out counters and the result beat
	always_comb begin
		count_d     = count_q;
		ovf_d       = ovf_q;
		res_d       = '0;
		if (state_q == BK_IDLE) begin
			if (job.kind == JOB_CLEAR) begin
				count_d = '0;
				ovf_d   = 1'b0;
			end else begin
				res_d.entry_value = job.id;
			end
		end else begin
			res_d.entry_value = key_q;
			if (do_insert) begin
				count_d        = count_q + CNT_W'(1);
				res_d.inserted = 1'b1;
			end else if (exhausted) begin
				ovf_d = 1'b1;
			end
		end
		count_now32       = 32'(count_q);
		count_new32       = 32'(count_d);
		if (do_insert) begin
			res_d.entry_index = count_now32[11:0];
		end
		res_d.set_count = count_new32[12:0];
		res_d.overflow  = ovf_d;
	end

	// Table write on append and registered read for the scan
	always_ff @(posedge clk) begin
		if (do_insert) begin
			id_table[count_q[ADDR_W-1:0]] <= key_q;
		end
		if (rd_en) begin
			rdata_q <= id_table[k_q[ADDR_W-1:0]];
		end
	end

	// Capture the search key
	always_ff @(posedge clk) begin
		if (take_job) begin
			key_q <= job.id;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_wr) begin
				count_q <= count_d;
				ovf_q   <= ovf_d;
			end
			if (take_job) begin
				k_q    <= '0;
				pend_q <= 1'b0;
			end else if (state_q == BK_SCAN) begin
				pend_q <= rd_en;
				if (rd_en) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
		end
	end

	// Store a result beat
	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q[res_wr_ptr_q] <= res_d;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= 1'b0;
			res_rd_ptr_q <= 1'b0;
			res_cnt_q    <= 2'd0;
		end else begin
			if (res_wr) begin
				res_wr_ptr_q <= ~res_wr_ptr_q;
			end
			if (res_rd) begin
				res_rd_ptr_q <= ~res_rd_ptr_q;
			end
			case ({res_wr, res_rd})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule
